// ===== hdl/ba_pkg.sv =====
// Shared types and constants of the buddy allocator.
package ba_pkg;

  localparam int ORDERS_DEF         = 8;
  localparam int MIN_BLOCK_LOG2_DEF = 5;

  // Widest fields over the whole parameter range (ORDERS up to 16).
  localparam int ORD_MAX_W = 5;
  localparam int BLK_MAX_W = 15;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic ST_OK  = 1'b0;
  localparam logic ST_OOM = 1'b1;

  typedef struct packed {
    logic        action;
    logic [31:0] request_size;
    logic [31:0] handle;
  } ba_in_t;

  typedef struct packed {
    logic [31:0] granted_handle;
    logic        status;
  } ba_out_t;

  // Decoded request: target order for allocate, block number for free.
  typedef struct packed {
    logic [ORD_MAX_W-1:0] ord;
    logic                 free_ok;
    logic [BLK_MAX_W-1:0] blk;
  } ba_dec_t;

endpackage

// ===== hdl/ba_ram.sv =====
// Generic simple dual-port RAM with registered read.
module ba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/ba_decode.sv =====
// Request decode: size to order, handle to block number with range check.
module ba_decode import ba_pkg::*; #(
  parameter int ORDERS         = ORDERS_DEF,
  parameter int MIN_BLOCK_LOG2 = MIN_BLOCK_LOG2_DEF
) (
  input  ba_in_t      item_i,
  input  logic [31:0] heap_base_i,
  output ba_dec_t     dec_o
);

  localparam int BW = ORDERS - 1;

  logic [31:0]          off;
  logic [ORD_MAX_W-1:0] ord;

  // Order is the number of block sizes not above the request.
  always_comb begin
    ord = '0;
    for (int k = 0; k < ORDERS; k++) begin
      if (item_i.request_size >= (32'd1 << (MIN_BLOCK_LOG2 + k))) begin
        ord = ord + 1'b1;
      end
    end
  end

  assign off = item_i.handle - 32'd1 - heap_base_i;

  assign dec_o.ord     = ord;
  assign dec_o.free_ok = (item_i.handle != 32'd0) &&
                         ((off >> (BW + MIN_BLOCK_LOG2)) == 32'd0) &&
                         (off[MIN_BLOCK_LOG2-1:0] == '0);
  assign dec_o.blk     = BLK_MAX_W'(off[BW+MIN_BLOCK_LOG2-1:MIN_BLOCK_LOG2]);

endmodule

// ===== hdl/buddy_allocator.sv =====
// Top level of the binary buddy allocator: sequencer, list counts, memories.
//
// One heap of 2^(ORDERS-1) minimum blocks of 2^MIN_BLOCK_LOG2 bytes. Free lists
// live in one RAM (one stack of block numbers per order), block order tags in a
// second RAM; both have a registered read. Items are handled one at a time.
// Allocate pops the lowest non-empty list at or above the target order, then
// splits one level at a time down to it (at most ORDERS-1 levels), pushing each
// upper half; when no list fits it reports out of memory. Free reads the block's
// order tag (a null or foreign handle goes straight to the result), then per
// merge level scans its list from the top for the buddy and moves the entries
// above it down to close the gap; a level whose buddy is not listed ends the
// merge and the block is pushed. A finished result sits in an output register,
// so the next item can be taken while it waits. heap_base is written over its
// own valid/ready port; the user must write it only while no item is in flight,
// and the block itself does not enforce this. No clearing pass: the one initial
// list entry is supplied by a reset flag.
module buddy_allocator import ba_pkg::*; #(
  parameter int ORDERS         = ORDERS_DEF,
  parameter int MIN_BLOCK_LOG2 = MIN_BLOCK_LOG2_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  ba_in_t      in_item_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output ba_out_t     out_item_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i
);

  localparam int BW   = ORDERS - 1;           // block number width
  localparam int OW   = $clog2(ORDERS);       // order index width
  localparam int OW1  = $clog2(ORDERS + 1);   // order incl. "too big"
  localparam int CW   = BW + 1;               // list depth counter
  localparam int HEAP = 1 << BW;
  localparam int EAW  = OW + BW;

  typedef enum logic [11:0] {
    S_IDLE     = 12'b0000_0000_0001,
    S_DECODE   = 12'b0000_0000_0010,
    S_POP      = 12'b0000_0000_0100,
    S_SPLIT    = 12'b0000_0000_1000,
    S_TAG      = 12'b0000_0001_0000,
    S_MERGE    = 12'b0000_0010_0000,
    S_SCAN_RD  = 12'b0000_0100_0000,
    S_SCAN_CMP = 12'b0000_1000_0000,
    S_MOVE_RD  = 12'b0001_0000_0000,
    S_MOVE_WR  = 12'b0010_0000_0000,
    S_PUSH     = 12'b0100_0000_0000,
    S_DONE     = 12'b1000_0000_0000
  } state_e;

  localparam logic [EAW-1:0] TOP_ADDR = {OW'(ORDERS - 1), {BW{1'b0}}};

  state_e          state_q, state_d;
  ba_in_t          item_q, item_d;
  logic [31:0]     heap_base_q, heap_base_d;
  logic [OW1-1:0]  ord_q, ord_d;
  logic [OW-1:0]   lvl_q, lvl_d;
  logic [BW-1:0]   blk_q, blk_d;
  logic [CW-1:0]   idx_q, idx_d;
  logic [CW-1:0]   cnt_q [ORDERS];
  logic [CW-1:0]   cnt_d [ORDERS];
  logic [31:0]     res_handle_q, res_handle_d;
  logic            res_oom_q, res_oom_d;
  logic            out_valid_q, out_valid_d;
  ba_out_t         out_q, out_d;
  logic            top_init_q, top_init_d;   // initial top-list entry not yet overwritten
  logic            init_hit_q, init_hit_d;

  ba_dec_t         dec;
  logic            ent_we;
  logic [EAW-1:0]  ent_waddr, ent_raddr;
  logic [BW-1:0]   ent_wdata, ent_raw, ent_rdata;
  logic            tag_we;
  logic [OW-1:0]   tag_rdata;
  logic [OW-1:0]   first;
  logic            first_found;
  logic [OW-1:0]   o;
  logic [BW-1:0]   buddy;
  logic [CW-1:0]   im1;

  ba_decode #(
    .ORDERS         (ORDERS),
    .MIN_BLOCK_LOG2 (MIN_BLOCK_LOG2)
  ) u_decode (
    .item_i      (item_q),
    .heap_base_i (heap_base_q),
    .dec_o       (dec)
  );

  ba_ram #(
    .WIDTH (BW),
    .DEPTH (ORDERS * HEAP)
  ) u_list_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .raddr_i (ent_raddr),
    .rdata_o (ent_raw)
  );

  ba_ram #(
    .WIDTH (OW),
    .DEPTH (HEAP)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (tag_we),
    .waddr_i (blk_q),
    .wdata_i (ord_q[OW-1:0]),
    .raddr_i (dec.blk[BW-1:0]),
    .rdata_o (tag_rdata)
  );

  // Until written, the first slot of the top list reads block zero.
  assign ent_rdata = init_hit_q ? '0 : ent_raw;

  // Lowest non-empty list at or above the requested order.
  always_comb begin
    first       = '0;
    first_found = 1'b0;
    for (int i = ORDERS - 1; i >= 0; i--) begin
      if ((cnt_q[i] != '0) && (ORD_MAX_W'(i) >= dec.ord)) begin
        first       = OW'(i);
        first_found = 1'b1;
      end
    end
  end

  assign o     = ord_q[OW-1:0];
  assign buddy = blk_q ^ (BW'(1) << o);
  assign im1   = idx_q - 1'b1;

  always_comb begin
    logic [CW-1:0] c;
    logic [OW-1:0] pl;
    state_d      = state_q;
    item_d       = item_q;
    heap_base_d  = heap_base_q;
    ord_d        = ord_q;
    lvl_d        = lvl_q;
    blk_d        = blk_q;
    idx_d        = idx_q;
    cnt_d        = cnt_q;
    res_handle_d = res_handle_q;
    res_oom_d    = res_oom_q;
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    ent_we       = 1'b0;
    ent_waddr    = '0;
    ent_wdata    = '0;
    ent_raddr    = '0;
    tag_we       = 1'b0;
    c            = '0;
    pl           = lvl_q - 1'b1;

    if (cfg_valid_i) begin
      heap_base_d = cfg_data_i;
    end
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          item_d  = in_item_i;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        res_handle_d = '0;
        res_oom_d    = ST_OK;
        if (item_q.action == ACT_ALLOC) begin
          if ((dec.ord >= ORD_MAX_W'(ORDERS)) || !first_found) begin
            res_oom_d = ST_OOM;
            state_d   = S_DONE;
          end else begin
            c            = cnt_q[first] - 1'b1;
            cnt_d[first] = c;
            ent_raddr    = {first, c[BW-1:0]};
            lvl_d        = first;
            ord_d        = dec.ord[OW1-1:0];
            state_d      = S_POP;
          end
        end else if (dec.free_ok) begin
          blk_d   = dec.blk[BW-1:0];
          state_d = S_TAG;
        end else begin
          state_d = S_DONE;
        end
      end
      S_POP: begin
        blk_d   = ent_rdata;
        state_d = S_SPLIT;
      end
      S_SPLIT: begin
        if (OW1'(lvl_q) > ord_q) begin
          // push upper half of the split onto the next lower list
          c = cnt_q[pl];
          if (c < CW'(HEAP)) begin
            ent_we    = 1'b1;
            ent_waddr = {pl, c[BW-1:0]};
            ent_wdata = blk_q + (BW'(1) << pl);
            cnt_d[pl] = c + 1'b1;
          end
          lvl_d = pl;
        end else begin
          tag_we       = 1'b1;
          res_handle_d = heap_base_q + 32'({blk_q, {MIN_BLOCK_LOG2{1'b0}}}) + 32'd1;
          state_d      = S_DONE;
        end
      end
      S_TAG: begin
        if (32'(tag_rdata) >= 32'(ORDERS - 1)) begin
          ord_d = OW1'(ORDERS - 1);
        end else begin
          ord_d = OW1'(tag_rdata);
        end
        state_d = S_MERGE;
      end
      S_MERGE: begin
        if (ord_q == OW1'(ORDERS - 1)) begin
          state_d = S_PUSH;
        end else begin
          idx_d   = cnt_q[o];
          state_d = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        // walk the list from the top looking for the buddy
        if (idx_q == '0) begin
          state_d = S_PUSH;
        end else begin
          ent_raddr = {o, im1[BW-1:0]};
          state_d   = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        if (ent_rdata == buddy) begin
          state_d = S_MOVE_RD;   // idx_q is the first entry above the hole
        end else begin
          idx_d   = im1;
          state_d = S_SCAN_RD;
        end
      end
      S_MOVE_RD: begin
        if (idx_q == cnt_q[o]) begin
          cnt_d[o] = cnt_q[o] - 1'b1;
          if (buddy < blk_q) begin
            blk_d = buddy;
          end
          ord_d   = ord_q + 1'b1;
          state_d = S_MERGE;
        end else begin
          ent_raddr = {o, idx_q[BW-1:0]};
          state_d   = S_MOVE_WR;
        end
      end
      S_MOVE_WR: begin
        ent_we    = 1'b1;
        ent_waddr = {o, im1[BW-1:0]};
        ent_wdata = ent_rdata;
        idx_d     = idx_q + 1'b1;
        state_d   = S_MOVE_RD;
      end
      S_PUSH: begin
        c = cnt_q[o];
        if (c < CW'(HEAP)) begin
          ent_we    = 1'b1;
          ent_waddr = {o, c[BW-1:0]};
          ent_wdata = blk_q;
          cnt_d[o]  = c + 1'b1;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d          = 1'b1;
          out_d.granted_handle = res_handle_q;
          out_d.status         = res_oom_q;
          state_d              = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign top_init_d = top_init_q && !(ent_we && (ent_waddr == TOP_ADDR));
  assign init_hit_d = top_init_q && (ent_raddr == TOP_ADDR);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      heap_base_q <= '0;
      out_valid_q <= 1'b0;
      top_init_q  <= 1'b1;
      init_hit_q  <= 1'b0;
      for (int i = 0; i < ORDERS; i++) begin
        cnt_q[i] <= (i == ORDERS - 1) ? CW'(1) : '0;
      end
    end else begin
      state_q     <= state_d;
      heap_base_q <= heap_base_d;
      out_valid_q <= out_valid_d;
      top_init_q  <= top_init_d;
      init_hit_q  <= init_hit_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q       <= item_d;
    ord_q        <= ord_d;
    lvl_q        <= lvl_d;
    blk_q        <= blk_d;
    idx_q        <= idx_d;
    res_handle_q <= res_handle_d;
    res_oom_q    <= res_oom_d;
    out_q        <= out_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign cfg_ready_o = 1'b1;

  // A waiting result is never overwritten by a finished item.
  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_valid_q && out_stall_i) |=> (state_q == S_DONE))
    else $error("result register overwritten");

  // Out of memory always reports a null handle.
  a_oom_null: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && res_oom_q == ST_OOM) |-> (res_handle_q == 32'd0))
    else $error("out_of_memory with non-null handle");

  // Splitting never goes below the requested order.
  a_split_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SPLIT) |-> (OW1'(lvl_q) >= ord_q))
    else $error("split below target order");

  // The gap-closing walk stays inside the list.
  a_move_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MOVE_RD) |-> (idx_q <= cnt_q[o] && idx_q != '0))
    else $error("list move index out of range");

endmodule

// ===== bench/buddy_allocator_test.sv =====
// Self-checking testbench for the buddy allocator: stimulus, allocation predictor, checker.
`timescale 1ns / 100ps
module buddy_allocator_test;
  import ba_pkg::*;

  localparam int ORDERS      = ORDERS_DEF;
  localparam int MINL        = MIN_BLOCK_LOG2_DEF;
  localparam int HEAP_BLOCKS = 1 << (ORDERS - 1);
  localparam int HEAP_BYTES  = HEAP_BLOCKS << MINL;
  localparam int LIMIT       = 3000000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  ba_in_t      in_item_i;
  logic        out_valid_o;
  logic        out_stall_i;
  ba_out_t     out_item_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i;

  buddy_allocator u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_item_i,
    .out_valid_o, .out_stall_i, .out_item_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  always #1 clk_i = ~clk_i;

  // Predicted allocator state
  logic [31:0]   heap_base;
  int unsigned   free_list [ORDERS][$];
  logic [2:0]    order_tag [HEAP_BLOCKS];
  bit            tag_set   [HEAP_BLOCKS];
  int unsigned   live_blocks[$];   // blocks handed out and not yet freed

  ba_out_t       pending_results[$];
  int            errors;
  int            cycles;
  int            items_sent;
  int            allocs_ok, allocs_oom, frees_sent;
  bit            quiet;            // no idling on either side while set

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result side: random stall, compared against oldest prediction
  always @(posedge clk_i) begin
    ba_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: %h", out_item_o);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_item_o.granted_handle !== want.granted_handle) begin
          $error("granted_handle expected %h actual %h",
                 want.granted_handle, out_item_o.granted_handle);
          errors++;
        end
        if (out_item_o.status !== want.status) begin
          $error("status expected %0d actual %0d", want.status, out_item_o.status);
          errors++;
        end
      end
    end
    out_stall_i <= quiet ? 1'b0 : ($urandom_range(99) < 8);
  end

  task automatic push_block(int unsigned ord, int unsigned blk);
    if (free_list[ord].size() < HEAP_BLOCKS) free_list[ord].push_back(blk);
  endtask

  // Remove the topmost copy of blk, keeping the rest in order
  function automatic bit take_block(int unsigned ord, int unsigned blk);
    for (int i = free_list[ord].size() - 1; i >= 0; i--) begin
      if (free_list[ord][i] == blk) begin
        free_list[ord].delete(i);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  task automatic predict_item(input ba_in_t it, output ba_out_t res);
    int unsigned ord, first, blk, buddy;
    logic [31:0] off;
    res = '0;
    res.status = ST_OK;
    if (it.action == ACT_ALLOC) begin
      ord = 0;
      while (ord < ORDERS && {32'd0, it.request_size} >= (64'd1 << (MINL + ord))) ord++;
      first = ORDERS;
      for (int i = ord; i < ORDERS; i++) begin
        if (free_list[i].size() != 0) begin
          first = i;
          break;
        end
      end
      if (first >= ORDERS) begin
        res.status = ST_OOM;
        allocs_oom++;
      end else begin
        blk = free_list[first].pop_back() & (HEAP_BLOCKS - 1);
        for (int i = first; i > ord; i--) push_block(i - 1, blk + (1 << (i - 1)));
        order_tag[blk] = ord;
        tag_set[blk] = 1'b1;
        res.granted_handle = heap_base + (blk << MINL) + 1;
        live_blocks.push_back(blk);
        allocs_ok++;
      end
    end else if (it.handle != 0) begin
      off = it.handle - 1 - heap_base;
      if (off < HEAP_BYTES && off[MINL-1:0] == 0) begin
        blk = off >> MINL;
        ord = order_tag[blk];
        while (ord < ORDERS - 1) begin
          buddy = blk ^ (1 << ord);
          if (!take_block(ord, buddy)) break;
          if (buddy < blk) blk = buddy;
          ord++;
        end
        push_block(ord, blk);
      end
    end
  endtask

  // Send one item; valid stays high across back-to-back items
  task automatic send_item(ba_in_t it);
    ba_out_t res;
    while (!quiet && $urandom_range(99) < 8) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    predict_item(it, res);
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_results.push_back(res);
    items_sent++;
    if (it.action == ACT_FREE) frees_sent++;
  endtask

  task automatic alloc(logic [31:0] size);
    ba_in_t it;
    it = '0;
    it.action = ACT_ALLOC;
    it.request_size = size;
    it.handle = $urandom();
    send_item(it);
  endtask

  task automatic free_handle(logic [31:0] h);
    ba_in_t it;
    it.action = ACT_FREE;
    it.request_size = $urandom();
    it.handle = h;
    send_item(it);
  endtask

  function automatic logic [31:0] handle_of(int unsigned blk);
    return heap_base + (blk << MINL) + 1;
  endfunction

  // Free a live block picked at random
  task automatic free_live();
    int idx;
    int unsigned blk;
    idx = $urandom_range(live_blocks.size() - 1);
    blk = live_blocks[idx];
    live_blocks.delete(idx);
    free_handle(handle_of(blk));
  endtask

  // Noise handle that never lands on a block without a tag
  function automatic logic [31:0] foreign_handle();
    logic [31:0] h, off;
    h = $urandom();
    off = h - 1 - heap_base;
    if (off < HEAP_BYTES && off[MINL-1:0] == 0 && !tag_set[off >> MINL]) h ^= 32'd1;
    return h;
  endfunction

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_heap_base(logic [31:0] v);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    heap_base = v;
    cfg_valid_i <= 1'b0;
  endtask

  // Size bounds of every order, oversize, empty heap, null and foreign frees, merges
  task automatic test_directed();
    alloc(32'd0);
    alloc(32'd31);
    alloc(32'd32);
    alloc(32'd4095);             // whole heap is no longer free
    alloc(32'd4096);             // oversized
    alloc(32'hFFFF_FFFF);        // oversized
    for (int o = 0; o < ORDERS; o++) alloc((32 << o) - 1);
    free_handle(32'd0);
    free_handle(heap_base + 32'd2);             // misaligned
    free_handle(heap_base + HEAP_BYTES + 1);    // past the heap
    while (live_blocks.size() != 0) free_live();
    alloc(32'd4095);             // merges back to one block unless a handle wrapped to null
    if (live_blocks.size() != 0) free_live();
  endtask

  task automatic test_random_mix(int n);
    int r, o;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 50) begin
        o = $urandom_range(ORDERS - 1);
        alloc($urandom_range((32 << o) - 1, 0));
      end else if (r < 55) begin
        alloc($urandom() | 32'h0000_1000);
      end else if (r < 92 && live_blocks.size() != 0) begin
        free_live();
      end else if (r < 95) begin
        free_handle(32'd0);
      end else begin
        free_handle(foreign_handle());
      end
    end
  endtask

  // Sender holds off until every result is back, then resumes
  task automatic test_drain_pause();
    for (int k = 0; k < 6; k++) alloc($urandom_range(200));
    wait_drained();
    while (live_blocks.size() != 0) free_live();
  endtask

  // Repeated frees of one block fill the order-0 list, then drain it
  task automatic test_full_list();
    int unsigned blk;
    while (live_blocks.size() != 0) free_live();
    alloc(32'd0);
    alloc(32'd0);
    blk = live_blocks[0];
    for (int k = 0; k < HEAP_BLOCKS + 2; k++) free_handle(handle_of(blk));
    for (int k = 0; k < HEAP_BLOCKS + 4; k++) alloc(32'd0);
    live_blocks.delete();
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    errors = 0;
    cycles = 0;
    items_sent = 0;
    allocs_ok = 0;
    allocs_oom = 0;
    frees_sent = 0;
    quiet = 1'b0;
    heap_base = '0;
    for (int o = 0; o < ORDERS; o++) free_list[o].delete();
    free_list[ORDERS-1].push_back(0);
    for (int b = 0; b < HEAP_BLOCKS; b++) begin
      order_tag[b] = '0;
      tag_set[b] = 1'b0;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    write_heap_base(32'hFFFF_FFFF);
    test_directed();
    write_heap_base(32'h8000_0000);
    test_random_mix(160);
    test_drain_pause();
    quiet = 1'b1;
    test_random_mix(100);
    quiet = 1'b0;
    write_heap_base(32'hFFFF_FFE0);
    test_random_mix(100);
    write_heap_base($urandom());
    test_full_list();
    write_heap_base(32'd0);
    test_random_mix(100);

    wait_drained();
    repeat (50) @(posedge clk_i);
    $display("%0d items: %0d grants, %0d out-of-memory, %0d frees, several heap bases",
             items_sent, allocs_ok, allocs_oom, frees_sent);
    $display("covered: every order, oversize, empty heap, null/foreign frees, full list");
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
